// File: rtl/bbhs_pkg.sv
// ----------------------------------------------------------------------------
// bbhs_pkg
// Shared types, constants and helpers for the heading servo control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bbhs_pkg;

    // field widths
    localparam int BUTTONS_W = 15;
    localparam int POS_W     = 12;
    localparam int SERVO_W   = 8;
    localparam int SPEED_W   = 8;
    localparam int ANGLE_W   = 9;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // register indexes, selected by paddr[2]
    localparam logic REG_HOLD_SPEED = 1'b0;
    localparam logic REG_TURN_SPEED = 1'b1;

    localparam logic [SPEED_W-1:0] HOLD_SPEED_RST = 8'd18;
    localparam logic [SPEED_W-1:0] TURN_SPEED_RST = 8'd30;

    // item kinds
    localparam logic CMD_TELEOP = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [SERVO_W-1:0] SERVO_NEUTRAL = 8'd90;
    localparam logic [SPEED_W-1:0] MAX_DEV       = 8'd90;
    localparam logic [ANGLE_W-1:0] HALF_TURN     = 9'd180;

    // encoder scaling: angle = ((4096 - pos) * 360) >> 12
    localparam int SPAN_W  = POS_W + 1;
    localparam int SCALE_W = 9;
    localparam int PROD_W  = SPAN_W + SCALE_W;
    localparam logic [SPAN_W-1:0]  POS_SPAN  = 13'd4096;
    localparam logic [SCALE_W-1:0] DEG_SCALE = 9'd360;

    // button bits
    localparam int BTN_KILL_A   = 8;
    localparam int BTN_KILL_B   = 0;
    localparam int BTN_KILL_C   = 1;
    localparam int BTN_TURN_FWD = 13;
    localparam int BTN_TURN_REV = 14;

    typedef enum logic [2:0] {
        HOLD_NONE     = 3'd0,
        HOLD_TGT0_A   = 3'd1,
        HOLD_TGT180_A = 3'd2,
        HOLD_TGT180_B = 3'd3,
        HOLD_TGT0_B   = 3'd4,
        HOLD_TGT90    = 3'd5,
        HOLD_TGT270   = 3'd6
    } hold_mode_t;

    typedef struct packed {
        logic [SPEED_W-1:0] hold_speed;
        logic [SPEED_W-1:0] turn_speed;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [SERVO_W-1:0] servo;
    } result_t;

    function automatic logic [ANGLE_W-1:0] hold_target(input hold_mode_t mode);
        logic [ANGLE_W-1:0] t;
        case (mode)
            HOLD_TGT180_A: t = 9'd180;
            HOLD_TGT180_B: t = 9'd180;
            HOLD_TGT90:    t = 9'd90;
            HOLD_TGT270:   t = 9'd270;
            default:       t = 9'd0;
        endcase
        return t;
    endfunction

    function automatic logic [SPEED_W-1:0] clamp_dev(input logic [SPEED_W-1:0] s);
        return (s > MAX_DEV) ? MAX_DEV : s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bbhs_regs.sv
// ----------------------------------------------------------------------------
// bbhs_regs
// APB register file holding the hold and surface-turn speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module bbhs_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bbhs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bbhs_pkg::DATA_W-1:0]   pwdata,
    output logic      [bbhs_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output bbhs_pkg::cfg_t                     cfg
);

    logic [bbhs_pkg::SPEED_W-1:0] hold_speed_reg;
    logic [bbhs_pkg::SPEED_W-1:0] turn_speed_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_speed_reg <= bbhs_pkg::HOLD_SPEED_RST;
            turn_speed_reg <= bbhs_pkg::TURN_SPEED_RST;
        end else if (wr_en) begin
            case (paddr[2])
                bbhs_pkg::REG_HOLD_SPEED: hold_speed_reg <= pwdata[bbhs_pkg::SPEED_W-1:0];
                bbhs_pkg::REG_TURN_SPEED: turn_speed_reg <= pwdata[bbhs_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bbhs_pkg::REG_HOLD_SPEED: prdata = {24'd0, hold_speed_reg};
            bbhs_pkg::REG_TURN_SPEED: prdata = {24'd0, turn_speed_reg};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.hold_speed = hold_speed_reg;
    assign cfg.turn_speed = turn_speed_reg;

endmodule

`default_nettype wire

// File: rtl/bbhs_step.sv
// ----------------------------------------------------------------------------
// bbhs_step
// Per-beat decision logic: teleop decode and bang-bang heading hold.
// ----------------------------------------------------------------------------
`default_nettype none

module bbhs_step (
    input  wire logic                            command,
    input  wire logic [bbhs_pkg::BUTTONS_W-1:0]  buttons,
    input  wire logic [bbhs_pkg::POS_W-1:0]      encoder_position,
    input  bbhs_pkg::hold_mode_t                 hold_mode,
    input  bbhs_pkg::cfg_t                       cfg,
    output bbhs_pkg::hold_mode_t                 hold_mode_next,
    output bbhs_pkg::result_t                    result
);

    logic [bbhs_pkg::SPEED_W-1:0] hold_dev;
    logic [bbhs_pkg::SPEED_W-1:0] turn_dev;
    logic [bbhs_pkg::SPAN_W-1:0]  span;
    logic [bbhs_pkg::PROD_W-1:0]  prod;
    logic [bbhs_pkg::ANGLE_W-1:0] angle;
    logic [bbhs_pkg::ANGLE_W-1:0] target;
    logic [bbhs_pkg::ANGLE_W-1:0] diff;
    logic                         fwd;
    logic                         kill;
    logic                         hold_active;
    bbhs_pkg::hold_mode_t         sel_mode;

    assign hold_dev = bbhs_pkg::clamp_dev(cfg.hold_speed);
    assign turn_dev = bbhs_pkg::clamp_dev(cfg.turn_speed);

    // encoder count to degrees, 0..360
    assign span  = bbhs_pkg::POS_SPAN - {1'b0, encoder_position};
    assign prod  = span * bbhs_pkg::DEG_SCALE;
    assign angle = prod[bbhs_pkg::PROD_W-2 -: bbhs_pkg::ANGLE_W];

    assign target = bbhs_pkg::hold_target(hold_mode);

    always_comb begin
        if (target > angle) begin
            fwd  = 1'b1;
            diff = target - angle;
        end else begin
            fwd  = 1'b0;
            diff = angle - target;
        end
        // take the short way around
        if (diff > bbhs_pkg::HALF_TURN) begin
            fwd = !fwd;
        end
    end

    assign hold_active = (hold_mode == bbhs_pkg::HOLD_TGT0_A)
                      || (hold_mode == bbhs_pkg::HOLD_TGT180_A)
                      || (hold_mode == bbhs_pkg::HOLD_TGT180_B)
                      || (hold_mode == bbhs_pkg::HOLD_TGT0_B)
                      || (hold_mode == bbhs_pkg::HOLD_TGT90)
                      || (hold_mode == bbhs_pkg::HOLD_TGT270);

    assign kill = buttons[bbhs_pkg::BTN_KILL_A] || buttons[bbhs_pkg::BTN_KILL_B]
               || buttons[bbhs_pkg::BTN_KILL_C];

    // lowest set bit of 2..7 picks the hold mode
    always_comb begin
        if (buttons[2])      sel_mode = bbhs_pkg::HOLD_TGT0_A;
        else if (buttons[3]) sel_mode = bbhs_pkg::HOLD_TGT180_A;
        else if (buttons[4]) sel_mode = bbhs_pkg::HOLD_TGT180_B;
        else if (buttons[5]) sel_mode = bbhs_pkg::HOLD_TGT0_B;
        else if (buttons[6]) sel_mode = bbhs_pkg::HOLD_TGT90;
        else if (buttons[7]) sel_mode = bbhs_pkg::HOLD_TGT270;
        else                 sel_mode = bbhs_pkg::HOLD_NONE;
    end

    always_comb begin
        hold_mode_next = hold_mode;
        result.valid   = 1'b0;
        result.servo   = bbhs_pkg::SERVO_NEUTRAL;
        case (command)
            bbhs_pkg::CMD_TELEOP: begin
                hold_mode_next = bbhs_pkg::HOLD_NONE;
                if (kill) begin
                    result.valid = 1'b1;
                end else if (buttons[bbhs_pkg::BTN_TURN_FWD]) begin
                    result.valid = 1'b1;
                    result.servo = bbhs_pkg::SERVO_NEUTRAL + turn_dev;
                end else if (buttons[bbhs_pkg::BTN_TURN_REV]) begin
                    result.valid = 1'b1;
                    result.servo = bbhs_pkg::SERVO_NEUTRAL - turn_dev;
                end else begin
                    hold_mode_next = sel_mode;
                end
            end
            bbhs_pkg::CMD_TICK: begin
                result.valid = hold_active;
                result.servo = fwd ? (bbhs_pkg::SERVO_NEUTRAL + hold_dev)
                                   : (bbhs_pkg::SERVO_NEUTRAL - hold_dev);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/bang_bang_heading_servo_control_unit.sv
// ----------------------------------------------------------------------------
// bang_bang_heading_servo_control_unit
// Heading hold for a continuous-rotation servo driven by teleop and encoder beats.
// ----------------------------------------------------------------------------
// One input beat is taken per clock while s_ready is high. A beat lands in
// an input register, is decided in one pass of compare and constant-scale
// logic, and its result (if any) then lands in the output register, which
// drives m_valid. The input register keeps accepting while a finished result
// waits on m_ready; only a second pending beat that needs the occupied output
// register holds s_ready low. Teleop beats with no kill or turn button and
// ticks outside a hold mode give no result.
`default_nettype none

module bang_bang_heading_servo_control_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_command,
    input  wire logic [bbhs_pkg::BUTTONS_W-1:0]  s_buttons,
    input  wire logic [bbhs_pkg::POS_W-1:0]      s_encoder_position,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [bbhs_pkg::SERVO_W-1:0]    m_servo_angle,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bbhs_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [bbhs_pkg::DATA_W-1:0]     pwdata,
    output logic      [bbhs_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready
);

    logic                             in_valid_reg;
    logic                             command_reg;
    logic [bbhs_pkg::BUTTONS_W-1:0]   buttons_reg;
    logic [bbhs_pkg::POS_W-1:0]       position_reg;
    logic                             out_valid_reg;
    logic [bbhs_pkg::SERVO_W-1:0]     servo_reg;
    bbhs_pkg::hold_mode_t             hold_mode_reg;
    bbhs_pkg::hold_mode_t             hold_mode_next;
    bbhs_pkg::result_t                result;
    bbhs_pkg::cfg_t                   cfg;
    logic                             advance;
    logic                             s_fire;

    bbhs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bbhs_step u_step (
        .command          (command_reg),
        .buttons          (buttons_reg),
        .encoder_position (position_reg),
        .hold_mode        (hold_mode_reg),
        .cfg              (cfg),
        .hold_mode_next   (hold_mode_next),
        .result           (result)
    );

    // a beat with no result never waits on the output side
    assign advance = in_valid_reg && (!result.valid || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_mode_reg <= bbhs_pkg::HOLD_NONE;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                hold_mode_reg <= hold_mode_next;
            end
            if (advance && result.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            command_reg  <= s_command;
            buttons_reg  <= s_buttons;
            position_reg <= s_encoder_position;
        end
        if (advance && result.valid) begin
            servo_reg <= result.servo;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_servo_angle = servo_reg;

    a_servo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_servo_angle <= 8'd180))
        else $error("servo value out of range");

    a_kill_neutral: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && command_reg == bbhs_pkg::CMD_TELEOP
         && (buttons_reg[bbhs_pkg::BTN_KILL_A] || buttons_reg[bbhs_pkg::BTN_KILL_B]
             || buttons_reg[bbhs_pkg::BTN_KILL_C]))
        |=> (m_valid && m_servo_angle == bbhs_pkg::SERVO_NEUTRAL))
        else $error("kill beat did not give neutral");

    a_teleop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && command_reg == bbhs_pkg::CMD_TELEOP && result.valid)
        |=> (hold_mode_reg == bbhs_pkg::HOLD_NONE))
        else $error("teleop command left a hold mode active");

    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && command_reg == bbhs_pkg::CMD_TICK
         && hold_mode_reg == bbhs_pkg::HOLD_NONE && !(m_valid && !m_ready))
        |=> !m_valid)
        else $error("tick without hold mode gave a result");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !s_ready)
        else $error("input register overwritten");

endmodule

`default_nettype wire

// File: sim/bbhs_servo_checker.sv
// ----------------------------------------------------------------------------
// bbhs_servo_checker
// Watches both beat channels and the register port of the heading servo unit,
// predicts each servo_angle from its own copy of the hold mode and speed
// registers, and compares every result beat against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module bbhs_servo_checker
    import bbhs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic                 s_command,
    input  wire logic [BUTTONS_W-1:0] s_buttons,
    input  wire logic [POS_W-1:0]     s_encoder_position,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [SERVO_W-1:0]   m_servo_angle,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    input  wire logic                 pready,
    output int                        mismatches,
    output int                        outstanding
);

    localparam int HOLD_BTN_LO = 2;
    localparam int HOLD_BTN_HI = 7;
    localparam int REPORT_CAP  = 100;

    localparam logic [21:0]        COUNTS_PER_TURN = 22'd4096;
    localparam logic [21:0]        DEG_PER_TURN    = 22'd360;
    localparam logic [ANGLE_W-1:0] FLIP_LIMIT      = 9'd180;

    logic [SPEED_W-1:0] hold_speed_reg;
    logic [SPEED_W-1:0] turn_speed_reg;
    hold_mode_t         heading_mode;
    logic [SERVO_W-1:0] expected_servo_q[$];
    int                 miss_count = 0;

    task automatic report_mismatch(input string what);
        miss_count++;
        if (miss_count <= REPORT_CAP)
            $display("[%0t] servo_angle check: %s", $time, what);
    endtask

    // works out the servo command for one input beat and updates the hold mode
    task automatic predict_servo(input logic cmd, input logic [BUTTONS_W-1:0] btn,
                                 input logic [POS_W-1:0] pos);
        logic [SPEED_W-1:0] hold_dev;
        logic [SPEED_W-1:0] turn_dev;
        logic [21:0]        scaled;
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] target;
        logic [ANGLE_W-1:0] gap;
        logic               fwd;
        int                 b;
        hold_dev = (hold_speed_reg > MAX_DEV) ? MAX_DEV : hold_speed_reg;
        turn_dev = (turn_speed_reg > MAX_DEV) ? MAX_DEV : turn_speed_reg;
        if (cmd == CMD_TELEOP) begin
            heading_mode = HOLD_NONE;
            if (btn[BTN_KILL_A] || btn[BTN_KILL_B] || btn[BTN_KILL_C]) begin
                expected_servo_q.push_back(SERVO_NEUTRAL);
            end else if (btn[BTN_TURN_FWD]) begin
                expected_servo_q.push_back(SERVO_NEUTRAL + turn_dev);
            end else if (btn[BTN_TURN_REV]) begin
                expected_servo_q.push_back(SERVO_NEUTRAL - turn_dev);
            end else begin
                // lowest hold button wins, so scan downward
                for (b = HOLD_BTN_HI; b >= HOLD_BTN_LO; b--) begin
                    if (btn[b])
                        heading_mode = hold_mode_t'(b - 1);
                end
            end
        end else if (heading_mode != HOLD_NONE && heading_mode <= HOLD_TGT270) begin
            scaled = (COUNTS_PER_TURN - {10'd0, pos}) * DEG_PER_TURN;
            angle  = scaled[20:12];
            case (heading_mode)
                HOLD_TGT180_A, HOLD_TGT180_B: target = 9'd180;
                HOLD_TGT90:                   target = 9'd90;
                HOLD_TGT270:                  target = 9'd270;
                default:                      target = 9'd0;
            endcase
            // a tie drives reverse
            fwd = (target > angle);
            gap = fwd ? (target - angle) : (angle - target);
            if (gap > FLIP_LIMIT)
                fwd = !fwd;
            expected_servo_q.push_back(fwd ? SERVO_NEUTRAL + hold_dev
                                           : SERVO_NEUTRAL - hold_dev);
        end
    endtask

    always @(posedge aclk) begin : watch
        logic [SERVO_W-1:0] want;
        if (!aresetn) begin
            hold_speed_reg = HOLD_SPEED_RST;
            turn_speed_reg = TURN_SPEED_RST;
            heading_mode   = HOLD_NONE;
            expected_servo_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_HOLD_SPEED: hold_speed_reg = pwdata[SPEED_W-1:0];
                    REG_TURN_SPEED: turn_speed_reg = pwdata[SPEED_W-1:0];
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_servo_q.size() == 0) begin
                    report_mismatch($sformatf("got %0d with no beat expected",
                                              m_servo_angle));
                end else begin
                    want = expected_servo_q.pop_front();
                    if (m_servo_angle !== want)
                        report_mismatch($sformatf("got %0d, expected %0d",
                                                  m_servo_angle, want));
                end
            end
            if (s_valid && s_ready)
                predict_servo(s_command, s_buttons, s_encoder_position);
        end
        outstanding <= expected_servo_q.size();
        mismatches  <= miss_count;
    end

endmodule

`default_nettype wire

// File: sim/tb_bang_bang_heading_servo_control_unit.sv
// ----------------------------------------------------------------------------
// tb_bang_bang_heading_servo_control_unit
// Drives teleop and encoder beats into the heading servo unit through several
// register settings and idle patterns; a checker beside the block predicts
// and compares every servo_angle beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bang_bang_heading_servo_control_unit;
    import bbhs_pkg::*;

    localparam int HALF_PERIOD      = 4;
    localparam int RESET_CYCLES     = 7;
    localparam int STALL_LIMIT      = 1000;
    localparam int SETTLE_CYCLES    = 6;
    localparam int NUM_PHASES       = 7;
    localparam int BEATS_PER_PHASE  = 250;
    localparam int HOLD_BTN_LO      = 2;
    localparam int HOLD_BTN_HI      = 7;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_command;
    logic [BUTTONS_W-1:0] s_buttons;
    logic [POS_W-1:0]     s_encoder_position;
    logic                 m_ready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    wire logic                 s_ready;
    wire logic                 m_valid;
    wire logic [SERVO_W-1:0]   m_servo_angle;
    wire logic [DATA_W-1:0]    prdata;
    wire logic                 pready;

    int mismatches;
    int outstanding;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    bang_bang_heading_servo_control_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_buttons          (s_buttons),
        .s_encoder_position (s_encoder_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_servo_angle      (m_servo_angle),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    bbhs_servo_checker servo_chk (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_buttons          (s_buttons),
        .s_encoder_position (s_encoder_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_servo_angle      (m_servo_angle),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // ends the run if no beat moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [BUTTONS_W-1:0] btn_bit(input int b);
        return BUTTONS_W'(1) << b;
    endfunction

    task automatic write_reg(input logic idx, input logic [SPEED_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W-SPEED_W){1'b0}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_beat(input logic cmd, input logic [BUTTONS_W-1:0] btn,
                             input logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_command          <= cmd;
        s_buttons          <= btn;
        s_encoder_position <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    // the field a beat does not use carries random bits
    task automatic send_teleop(input logic [BUTTONS_W-1:0] btn);
        send_beat(CMD_TELEOP, btn, POS_W'($urandom));
    endtask

    task automatic send_tick(input logic [POS_W-1:0] pos);
        send_beat(CMD_TICK, BUTTONS_W'($urandom), pos);
    endtask

    task automatic send_random_beat();
        int                   pick;
        logic [BUTTONS_W-1:0] btn;
        logic [POS_W-1:0]     pos;
        pick = $urandom_range(0, 99);
        btn  = BUTTONS_W'($urandom);
        pos  = POS_W'($urandom);
        if (pick < 8) begin
            case ($urandom_range(0, 2))
                0:       btn[BTN_KILL_A] = 1'b1;
                1:       btn[BTN_KILL_B] = 1'b1;
                default: btn[BTN_KILL_C] = 1'b1;
            endcase
            send_teleop(btn);
        end else if (pick < 20) begin
            btn[BTN_KILL_A] = 1'b0;
            btn[BTN_KILL_B] = 1'b0;
            btn[BTN_KILL_C] = 1'b0;
            if (!btn[BTN_TURN_FWD])
                btn[BTN_TURN_REV] = 1'b1;
            send_teleop(btn);
        end else if (pick < 40) begin
            btn[BTN_KILL_A]   = 1'b0;
            btn[BTN_KILL_B]   = 1'b0;
            btn[BTN_KILL_C]   = 1'b0;
            btn[BTN_TURN_FWD] = 1'b0;
            btn[BTN_TURN_REV] = 1'b0;
            // mostly a single hold button, sometimes several
            if ($urandom_range(0, 1) == 0)
                btn[HOLD_BTN_HI:HOLD_BTN_LO] = '0;
            if (btn[HOLD_BTN_HI:HOLD_BTN_LO] == '0)
                btn[$urandom_range(HOLD_BTN_LO, HOLD_BTN_HI)] = 1'b1;
            send_teleop(btn);
        end else if (pick < 90) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 4))
                    0:       pos = 12'd0;
                    1:       pos = 12'd4095;
                    2:       pos = 12'd2048;
                    3:       pos = 12'd1024;
                    default: pos = 12'd3072;
                endcase
            end
            send_tick(pos);
        end else begin
            send_teleop(btn);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_teleop('0);
        send_tick(12'd0);
        send_teleop(btn_bit(2));
        send_tick(12'd4095);
        send_tick(12'd0);
        send_tick(12'd2048);
        send_teleop(btn_bit(3) | btn_bit(7) | btn_bit(10));
        send_tick(12'd2048);
        send_tick(12'd1024);
        send_teleop(btn_bit(4));
        send_tick(12'd4095);
        send_teleop(btn_bit(5));
        send_tick(12'd2047);
        send_teleop(btn_bit(6));
        send_tick(12'd3072);
        send_teleop(btn_bit(7));
        send_tick(12'd0);
        send_tick(12'd4095);
        send_teleop(btn_bit(BTN_KILL_A));
        send_tick(12'd1024);
        send_teleop(btn_bit(BTN_KILL_B));
        send_teleop(btn_bit(BTN_KILL_C));
        send_teleop(btn_bit(BTN_TURN_FWD));
        send_teleop(btn_bit(BTN_TURN_REV));
        send_teleop(btn_bit(BTN_TURN_FWD) | btn_bit(BTN_TURN_REV));
        send_teleop({BUTTONS_W{1'b1}});
    endtask

    initial begin
        int                 phase;
        int                 n;
        logic [SPEED_W-1:0] hold_val;
        logic [SPEED_W-1:0] turn_val;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_command          = CMD_TELEOP;
        s_buttons          = '0;
        s_encoder_position = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // registers still hold their reset values here
        run_directed();
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
            case (phase)
                0: begin hold_val = 8'd0;   turn_val = 8'd255; end
                1: begin hold_val = 8'd255; turn_val = 8'd0;   sender_idle_pct = 74; end
                2: begin hold_val = 8'd90;  turn_val = 8'd91;  receiver_stall_pct = 74; end
                3: begin
                    hold_val = 8'd91;
                    turn_val = 8'd90;
                    sender_idle_pct    = 18;
                    receiver_stall_pct = 18;
                end
                4: begin hold_val = SPEED_W'($urandom); turn_val = SPEED_W'($urandom); end
                5: begin hold_val = 8'd255; turn_val = 8'd255; receiver_stall_pct = 74; end
                default: begin
                    hold_val = 8'd1;
                    turn_val = 8'd89;
                    sender_idle_pct    = 18;
                    receiver_stall_pct = 18;
                end
            endcase
            write_reg(REG_HOLD_SPEED, hold_val);
            write_reg(REG_TURN_SPEED, turn_val);
            for (n = 0; n < BEATS_PER_PHASE; n++)
                send_random_beat();
            drain();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
